[hdl/obbsat_pkg.sv]
// Package for the oriented box pair collision block.
// Constants for the sine polynomial, field widths and word layouts. No dependencies.
`default_nettype none
package obbsat_pkg;
	localparam int IN_W  = 288;	// 284 bits of fields, zero padded to whole bytes
	localparam int OUT_W = 64;

	localparam logic [14:0] SIN_A = 15'd25736;
	localparam logic [13:0] SIN_B = 14'd10512;
	localparam logic [10:0] SIN_C = 11'd1160;
	localparam logic [15:0] QUARTER = 16'd16384;
	localparam logic [30:0] DEPTH_MAX = 31'h7FFF_FFFF;

	// input word bit offsets
	localparam int ACX_LO = 0;
	localparam int ACZ_LO = 32;
	localparam int AHX_LO = 64;
	localparam int AHZ_LO = 95;
	localparam int AYAW_LO = 126;
	localparam int BCX_LO = 142;
	localparam int BCZ_LO = 174;
	localparam int BHX_LO = 206;
	localparam int BHZ_LO = 237;
	localparam int BYAW_LO = 268;
endpackage
`default_nettype wire

[hdl/obb_pair_sat_collision.sv]
// Top level: separating axis test on two 2D oriented boxes, 11-stage pipeline.
// Depends on obbsat_pkg.
//
// Usage: one box pair per word on the s_ channel, one result word per pair on m_.
// s_tdata (low bit up): a_center_x[31:0], a_center_z[63:32], a_half_x[94:64],
//   a_half_z[125:95], a_yaw[141:126], b_center_x[173:142], b_center_z[205:174],
//   b_half_x[236:206], b_half_z[267:237], b_yaw[283:268], zero pad to 287.
// m_tdata (low bit up): hit[0], normal_x[16:1], normal_z[32:17], depth[63:33].
// Throughput: one pair per cycle while the receiver does not stall the output (see below).
// Stages: quadrant fold and center offsets, four for the sine polynomial (one
// multiply each), then products of axis dots and center offsets, their sums,
// radius products, overlaps, a pairwise minimum and the final select with depth
// saturation in the output register.
// All stages move on one enable; when the receiver holds m_tready low with a
// word waiting, the whole pipe freezes and s_tready drops, so nothing is lost.
// Reset clears every valid bit; the pipe comes up empty and ready.
// Results leave in input order; there is no state carried between pairs.
`default_nettype none
module obb_pair_sat_collision (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [obbsat_pkg::IN_W-1:0]   s_tdata,	// see header for fields
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [obbsat_pkg::OUT_W-1:0]       m_tdata	// hit, normal_x, normal_z, depth
);
	import obbsat_pkg::*;

	logic en;
	logic [9:0] v_q;	// valid of stages 1..10

	// stage 1
	logic [14:0] x_s1 [4];
	logic neg_s1 [4];
	logic signed [32:0] dx_s1, dz_s1;
	logic [30:0] h_s1 [4];
	// stage 2..4
	logic [14:0] x_s2 [4], x2_s2 [4], x_s3 [4], x2_s3 [4], x_s4 [4];
	logic [13:0] t_s3 [4];
	logic [14:0] u_s4 [4];
	logic neg_s2 [4], neg_s3 [4], neg_s4 [4];
	logic signed [32:0] dx_s2, dz_s2, dx_s3, dz_s3, dx_s4, dz_s4, dx_s5, dz_s5;
	logic [30:0] h_s2 [4], h_s3 [4], h_s4 [4], h_s5 [4], h_s6 [4], h_s7 [4];
	// stage 5: sines, order A cos, A sin, B cos, B sin
	logic signed [15:0] sn_s5 [4];
	logic signed [15:0] axx [4], axz [4];
	// stage 6
	logic signed [31:0] dpa_s6 [4][4], dpb_s6 [4][4];
	logic signed [48:0] ddx_s6 [4], ddz_s6 [4];
	logic signed [15:0] axx_s6 [4], axz_s6 [4], axx_s7 [4], axz_s7 [4];
	logic signed [15:0] axx_s8 [4], axz_s8 [4];
	// stage 7
	logic [15:0] dm_s7 [4][4];
	logic signed [49:0] dist_s7 [4], dist_s8 [4];
	// stage 8
	logic [46:0] rp_s8 [4][4];
	// stage 9
	logic signed [51:0] ov_s9 [4];
	logic signed [15:0] nx_s9 [4], nz_s9 [4];
	// stage 10
	logic sep_s10;
	logic signed [51:0] ovl_s10, ovh_s10;
	logic signed [15:0] nxl_s10, nzl_s10, nxh_s10, nzh_s10;
	// output
	logic hit_q;
	logic signed [15:0] nx_q, nz_q;
	logic [30:0] depth_q;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tdata  = {depth_q, nz_q, nx_q, hit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q      <= '0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			v_q      <= {v_q[8:0], s_tvalid};
			m_tvalid <= v_q[9];
		end
	end

	// axes from sines: A.x (c,-s), A.z (s,c), B.x, B.z
	always_comb begin
		axx[0] = sn_s5[0]; axz[0] = -sn_s5[1];
		axx[1] = sn_s5[1]; axz[1] = sn_s5[0];
		axx[2] = sn_s5[2]; axz[2] = -sn_s5[3];
		axx[3] = sn_s5[3]; axz[3] = sn_s5[2];
	end

	always_ff @(posedge clk) begin
		logic [15:0] ang [4];
		logic [29:0] m30;
		logic [25:0] m26;
		logic [28:0] m29;
		logic signed [32:0] sd;
		logic [32:0] ad;
		logic signed [49:0] s50;
		logic [49:0] rsum;
		logic [48:0] adist;
		logic signed [51:0] ov;
		if (en) begin
			// stage 1: quadrant fold
			ang[0] = s_tdata[AYAW_LO +: 16] + QUARTER;
			ang[1] = s_tdata[AYAW_LO +: 16];
			ang[2] = s_tdata[BYAW_LO +: 16] + QUARTER;
			ang[3] = s_tdata[BYAW_LO +: 16];
			for (int k = 0; k < 4; k++) begin
				x_s1[k]   <= ang[k][14] ? 15'(QUARTER - {2'b00, ang[k][13:0]})
					: {1'b0, ang[k][13:0]};
				neg_s1[k] <= ang[k][15];
			end
			dx_s1 <= 33'(signed'(s_tdata[BCX_LO +: 32])) - 33'(signed'(s_tdata[ACX_LO +: 32]));
			dz_s1 <= 33'(signed'(s_tdata[BCZ_LO +: 32])) - 33'(signed'(s_tdata[ACZ_LO +: 32]));
			h_s1[0] <= s_tdata[AHX_LO +: 31];
			h_s1[1] <= s_tdata[AHZ_LO +: 31];
			h_s1[2] <= s_tdata[BHX_LO +: 31];
			h_s1[3] <= s_tdata[BHZ_LO +: 31];

			// stages 2..5: polynomial, one product per stage
			for (int k = 0; k < 4; k++) begin
				m30 = 30'(x_s1[k]) * 30'(x_s1[k]);
				x2_s2[k] <= m30[28:14];
				x_s2[k] <= x_s1[k]; neg_s2[k] <= neg_s1[k];

				m26 = 26'(SIN_C) * 26'(x2_s2[k]);
				t_s3[k] <= SIN_B - {2'b00, m26[25:14]};
				x_s3[k] <= x_s2[k]; x2_s3[k] <= x2_s2[k]; neg_s3[k] <= neg_s2[k];

				m29 = 29'(t_s3[k]) * 29'(x2_s3[k]);
				u_s4[k] <= SIN_A - {1'b0, m29[27:14]};
				x_s4[k] <= x_s3[k]; neg_s4[k] <= neg_s3[k];

				m30 = 30'(x_s4[k]) * 30'(u_s4[k]);
				sn_s5[k] <= neg_s4[k] ? -signed'(m30[29:14]) : signed'(m30[29:14]);
			end
			dx_s2 <= dx_s1; dz_s2 <= dz_s1; dx_s3 <= dx_s2; dz_s3 <= dz_s2;
			dx_s4 <= dx_s3; dz_s4 <= dz_s3; dx_s5 <= dx_s4; dz_s5 <= dz_s4;
			h_s2 <= h_s1; h_s3 <= h_s2; h_s4 <= h_s3; h_s5 <= h_s4;
			h_s6 <= h_s5; h_s7 <= h_s6;

			// stage 6: axis dot products and center offset products
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					dpa_s6[i][j] <= 32'(axx[i]) * 32'(axx[j]);
					dpb_s6[i][j] <= 32'(axz[i]) * 32'(axz[j]);
				end
				ddx_s6[i] <= 49'(dx_s5) * 49'(axx[i]);
				ddz_s6[i] <= 49'(dz_s5) * 49'(axz[i]);
			end
			axx_s6 <= axx; axz_s6 <= axz;

			// stage 7: dot magnitudes at Q14, projected distances
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					sd = 33'(dpa_s6[i][j]) + 33'(dpb_s6[i][j]);
					ad = sd[32] ? 33'(-sd) : 33'(sd);
					dm_s7[i][j] <= ad[29:14];
				end
				dist_s7[i] <= 50'(ddx_s6[i]) + 50'(ddz_s6[i]);
			end
			axx_s7 <= axx_s6; axz_s7 <= axz_s6;

			// stage 8: radius products
			for (int i = 0; i < 4; i++)
				for (int j = 0; j < 4; j++)
					rp_s8[i][j] <= 47'(dm_s7[i][j]) * 47'(h_s7[j]);
			dist_s8 <= dist_s7; axx_s8 <= axx_s7; axz_s8 <= axz_s7;

			// stage 9: overlaps and signed normals
			for (int i = 0; i < 4; i++) begin
				rsum = 50'(rp_s8[i][0]) + 50'(rp_s8[i][1]) + 50'(rp_s8[i][2])
					+ 50'(rp_s8[i][3]);
				s50 = dist_s8[i];
				adist = s50[49] ? 49'(-s50) : 49'(s50);
				ov_s9[i] <= signed'({2'b00, rsum}) - signed'({3'b000, adist});
				nx_s9[i] <= dist_s8[i][49] ? -axx_s8[i] : axx_s8[i];
				nz_s9[i] <= dist_s8[i][49] ? -axz_s8[i] : axz_s8[i];
			end

			// stage 10: separation flag, minimum within each pair (ties keep first)
			sep_s10 <= (ov_s9[0] <= 0) || (ov_s9[1] <= 0) || (ov_s9[2] <= 0)
				|| (ov_s9[3] <= 0);
			if (ov_s9[1] < ov_s9[0]) begin
				ovl_s10 <= ov_s9[1]; nxl_s10 <= nx_s9[1]; nzl_s10 <= nz_s9[1];
			end else begin
				ovl_s10 <= ov_s9[0]; nxl_s10 <= nx_s9[0]; nzl_s10 <= nz_s9[0];
			end
			if (ov_s9[3] < ov_s9[2]) begin
				ovh_s10 <= ov_s9[3]; nxh_s10 <= nx_s9[3]; nzh_s10 <= nz_s9[3];
			end else begin
				ovh_s10 <= ov_s9[2]; nxh_s10 <= nx_s9[2]; nzh_s10 <= nz_s9[2];
			end

			// output register: final pick and depth saturation
			if (sep_s10) begin
				hit_q <= 1'b0; nx_q <= '0; nz_q <= '0; depth_q <= '0;
			end else begin
				hit_q <= 1'b1;
				if (ovh_s10 < ovl_s10) begin
					ov = ovh_s10; nx_q <= nxh_s10; nz_q <= nzh_s10;
				end else begin
					ov = ovl_s10; nx_q <= nxl_s10; nz_q <= nzl_s10;
				end
				depth_q <= (ov[51:45] != '0) ? DEPTH_MAX : ov[44:14];
			end
		end
	end
endmodule
`default_nettype wire

[hdl/obbsat_chk.sv]
// Port checker for obb_pair_sat_collision, bound to the top level.
// Depends on obbsat_pkg.
`default_nettype none
module obbsat_chk (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        s_tready,
	input wire logic                        m_tvalid,
	input wire logic                        m_tready,
	input wire logic [obbsat_pkg::OUT_W-1:0] m_tdata
);
	import obbsat_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("result word dropped");
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("stalled word changed");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[OUT_W-1:1] == '0)
		else $error("miss with nonzero normal or depth");
	a_hit_normal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[32:1] != '0)
		else $error("hit with zero normal");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready) else $error("input stalled without cause");
endmodule

bind obb_pair_sat_collision obbsat_chk u_obbsat_chk (
	.clk(clk), .arst_n(arst_n), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
